// ===== rtl/cshr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cshr_pkg: shared types and arithmetic for the conic surface ray hit core
// Fixed-point format, saturating add and subtract, queue entry type and
// the pipeline latencies of the arithmetic units.
// ----------------------------------------------------------------------------
package cshr_pkg;

  localparam int W = 48;
  localparam int FRAC = 32;
  localparam int HALF = W / 2;

  typedef logic signed [W-1:0] word_t;

  localparam word_t SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam word_t SAT_MIN = {1'b1, {(W-1){1'b0}}};
  localparam word_t ONE = (FRAC >= W - 1) ? SAT_MAX : word_t'(W'(1) << FRAC);

  // Register indexes of the configuration port.
  localparam logic REG_CURVATURE = 1'b0;
  localparam logic REG_CONIC = 1'b1;

  // Square root: bits of the root of a positive word scaled by 2^FRAC.
  localparam int SQRT_BITS = (W + FRAC) / 2;
  localparam int MUL_LAT = 2;
  localparam int SQRT_LAT = SQRT_BITS;
  localparam int DIV_LAT = W + 1;
  localparam int FRONT_LAST = 10;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef struct packed {
    word_t px;
    word_t py;
    word_t vx;
    word_t vy;
    word_t vz;
    word_t f;
    word_t g;
    word_t h;
    logic  hit;
  } qent_t;

  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? SAT_MIN : SAT_MAX;
    return s[W-1:0];
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? SAT_MIN : SAT_MAX;
    return s[W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cshr_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cshr_mul: two-stage fixed-point multiplier
// Sign-magnitude product from four half-width partial products, rounded
// half away from zero at the binary point and saturated.
// ----------------------------------------------------------------------------
module cshr_mul import cshr_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  word_t a,
  input  word_t b,
  output word_t p
);

  logic [W-1:0] ma, mb;
  logic [W-1:0] pll, plh, phl, phh;
  logic neg;
  logic [2*W-1:0] sum;
  logic [2*W-FRAC-1:0] mag;
  logic ovf;
  word_t mres, res;

  assign ma = a[W-1] ? (~a + 1'b1) : a;
  assign mb = b[W-1] ? (~b + 1'b1) : b;

  always_comb begin
    sum = (2*W)'(pll) + ((2*W)'(plh) << HALF) + ((2*W)'(phl) << HALF)
        + ((2*W)'(phh) << W) + ((2*W)'(1) << (FRAC - 1));
    mag = sum[2*W-1:FRAC];
    ovf = |mag[2*W-FRAC-1:W-1];
    mres = {1'b0, mag[W-2:0]};
    if (ovf) res = neg ? SAT_MIN : SAT_MAX;
    else res = neg ? -mres : mres;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pll <= ma[HALF-1:0] * mb[HALF-1:0];
      plh <= ma[HALF-1:0] * mb[W-1:HALF];
      phl <= ma[W-1:HALF] * mb[HALF-1:0];
      phh <= ma[W-1:HALF] * mb[W-1:HALF];
      neg <= a[W-1] ^ b[W-1];
      p <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cshr_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cshr_sqrt: pipelined fixed-point square root
// One root bit per stage; non-positive inputs give zero.
// ----------------------------------------------------------------------------
module cshr_sqrt import cshr_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  word_t v,
  output word_t r
);

  localparam int SB = SQRT_BITS;
  localparam int XW = 2 * SB;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [SB+2:0] rem;
    logic [SB-1:0] root;
  } sq_t;

  sq_t st [SB];
  sq_t first_in;

  function automatic sq_t sq_step(sq_t s);
    sq_t o;
    logic [SB+2:0] r2, trial;
    r2 = {s.rem[SB:0], s.x[XW-1:XW-2]};
    trial = {1'b0, s.root, 2'b01};
    o.x = s.x << 2;
    if (r2 >= trial) begin
      o.rem = r2 - trial;
      o.root = {s.root[SB-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.root = {s.root[SB-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    first_in.x = (!v[W-1] && v != '0) ? (XW'($unsigned(v)) << FRAC) : '0;
    first_in.rem = '0;
    first_in.root = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= sq_step(first_in);
      for (int i = 1; i < SB; i++) st[i] <= sq_step(st[i-1]);
    end
  end

  assign r = word_t'(st[SB-1].root);

endmodule
`default_nettype wire

// ===== rtl/cshr_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cshr_div: pipelined fixed-point divider
// Setup stage with overflow check, one restoring quotient bit per stage,
// then sign and saturation. Quotient magnitude truncates toward zero.
// ----------------------------------------------------------------------------
module cshr_div import cshr_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  word_t n,
  input  word_t d,
  output word_t q
);

  localparam int QB = W - 1;

  typedef struct packed {
    logic [W-1:0]  rem;
    logic [QB-1:0] nlow;
    logic [QB-1:0] quo;
    logic [W-1:0]  md;
    logic neg;
    logic dzero;
    logic nzero;
    logic nneg;
    logic ovf;
  } dv_t;

  dv_t st [QB+1];
  dv_t setup;
  logic [W-1:0] mn;
  logic [W+FRAC-1:0] nn;
  word_t qmag, res;

  function automatic dv_t dv_step(dv_t s);
    dv_t o;
    logic [W:0] r2;
    o = s;
    r2 = {s.rem, s.nlow[QB-1]};
    o.nlow = s.nlow << 1;
    if (r2 >= {1'b0, s.md}) begin
      o.rem = W'(r2 - {1'b0, s.md});
      o.quo = {s.quo[QB-2:0], 1'b1};
    end else begin
      o.rem = W'(r2);
      o.quo = {s.quo[QB-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    mn = n[W-1] ? (~n + 1'b1) : n;
    nn = {mn, {FRAC{1'b0}}};
    setup.md = d[W-1] ? (~d + 1'b1) : d;
    setup.rem = W'(nn >> QB);
    setup.nlow = nn[QB-1:0];
    setup.quo = '0;
    setup.neg = n[W-1] ^ d[W-1];
    setup.dzero = (d == '0);
    setup.nzero = (n == '0);
    setup.nneg = n[W-1];
    // Quotient reaches 2^(W-1) exactly when the dividend top bits reach the divisor.
    setup.ovf = (W'(nn >> QB) >= setup.md);
  end

  always_comb begin
    qmag = {1'b0, st[QB].quo};
    if (st[QB].dzero) res = st[QB].nzero ? '0 : (st[QB].nneg ? SAT_MIN : SAT_MAX);
    else if (st[QB].ovf) res = st[QB].neg ? SAT_MIN : SAT_MAX;
    else res = st[QB].neg ? -qmag : qmag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= setup;
      for (int i = 1; i <= QB; i++) st[i] <= dv_step(st[i-1]);
      q <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cshr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cshr_front: ray intake and hit classification
// Computes f, g and the discriminant h, flags whether the ray hits and
// hands each ray to the queue.
// ----------------------------------------------------------------------------
module cshr_front import cshr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  word_t curv,
  input  word_t conic,
  input  logic  in_valid,
  output logic  in_stall,
  input  word_t pos_x,
  input  word_t pos_y,
  input  word_t dir_x,
  input  word_t dir_y,
  input  word_t dir_z,
  input  logic  q_full,
  input  logic  q_pop,
  output logic  push,
  output qent_t entry
);

  localparam int L = FRONT_LAST;

  logic en;
  logic [L:0] fv;
  qent_t fc [L+1];
  word_t m_pxx, m_pyy, m_vxpx, m_vypy, m_kvz, m_kvzvz;
  word_t m_f, m_cs, m_cf, m_gg, m_cfk;
  word_t sum1, sum2, onek, onek6, onek7, gg9, hval;

  // The front pipeline holds back only when its last stage has a ray that the queue cannot take.
  assign en = !(fv[L] && q_full && !q_pop);
  assign in_stall = !en;
  assign push = fv[L] && en;
  assign entry = fc[L];
  assign hval = sat_sub(gg9, m_cfk);

  cshr_mul u_pxx   (.clk(clk), .en(en), .a(fc[0].px), .b(fc[0].px), .p(m_pxx));
  cshr_mul u_pyy   (.clk(clk), .en(en), .a(fc[0].py), .b(fc[0].py), .p(m_pyy));
  cshr_mul u_vxpx  (.clk(clk), .en(en), .a(fc[0].vx), .b(fc[0].px), .p(m_vxpx));
  cshr_mul u_vypy  (.clk(clk), .en(en), .a(fc[0].vy), .b(fc[0].py), .p(m_vypy));
  cshr_mul u_kvz   (.clk(clk), .en(en), .a(conic), .b(fc[0].vz), .p(m_kvz));
  cshr_mul u_kvzvz (.clk(clk), .en(en), .a(m_kvz), .b(fc[2].vz), .p(m_kvzvz));
  cshr_mul u_f     (.clk(clk), .en(en), .a(curv), .b(sum1), .p(m_f));
  cshr_mul u_cs    (.clk(clk), .en(en), .a(curv), .b(sum2), .p(m_cs));
  cshr_mul u_cf    (.clk(clk), .en(en), .a(curv), .b(m_f), .p(m_cf));
  cshr_mul u_gg    (.clk(clk), .en(en), .a(fc[6].g), .b(fc[6].g), .p(m_gg));
  cshr_mul u_cfk   (.clk(clk), .en(en), .a(m_cf), .b(onek7), .p(m_cfk));

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (en) begin
      fv[0] <= in_valid;
      for (int i = 1; i <= L; i++) fv[i] <= fv[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fc[0].px <= pos_x;
      fc[0].py <= pos_y;
      fc[0].vx <= dir_x;
      fc[0].vy <= dir_y;
      fc[0].vz <= dir_z;
      fc[0].f <= '0;
      fc[0].g <= '0;
      fc[0].h <= '0;
      fc[0].hit <= 1'b0;
      for (int i = 1; i < 6; i++) fc[i] <= fc[i-1];
      // Stage 6 picks up f and g; the last stage picks up h and the hit flag.
      fc[6] <= '{px: fc[5].px, py: fc[5].py, vx: fc[5].vx, vy: fc[5].vy,
                 vz: fc[5].vz, f: m_f, g: sat_sub(fc[5].vz, m_cs), h: fc[5].h,
                 hit: fc[5].hit};
      for (int i = 7; i < L; i++) fc[i] <= fc[i-1];
      fc[L] <= '{px: fc[L-1].px, py: fc[L-1].py, vx: fc[L-1].vx, vy: fc[L-1].vy,
                 vz: fc[L-1].vz, f: fc[L-1].f, g: fc[L-1].g, h: hval,
                 hit: !hval[W-1] && (hval != '0)};
      sum1 <= sat_add(m_pxx, m_pyy);
      sum2 <= sat_add(m_vxpx, m_vypy);
      onek <= sat_add(ONE, m_kvzvz);
      onek6 <= onek;
      onek7 <= onek6;
      gg9 <= m_gg;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cshr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cshr_back: hit point and surface normal
// Takes classified rays from the queue, solves for t, forms the hit point
// and the unit normal, and holds the result in the output register.
// ----------------------------------------------------------------------------
module cshr_back import cshr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  word_t curv,
  input  word_t conic,
  input  logic  q_valid,
  input  qent_t q_head,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t hit_x,
  output word_t hit_y,
  output word_t hit_z,
  output word_t norm_x,
  output word_t norm_y,
  output word_t norm_z,
  output logic  status
);

  localparam int S_R    = SQRT_LAT;
  localparam int S_DEN  = S_R + 1;
  localparam int S_T    = S_DEN + DIV_LAT;
  localparam int S_HZ   = S_T + MUL_LAT;
  localparam int S_HX   = S_HZ + 1;
  localparam int S_A    = S_HZ + MUL_LAT;
  localparam int S_Q1   = S_A + 1;
  localparam int S_C    = S_A + MUL_LAT;
  localparam int S_Q    = S_C + 1;
  localparam int S_RQ   = S_Q + SQRT_LAT;
  localparam int S_COEF = S_RQ + DIV_LAT;
  localparam int S_N    = S_COEF + MUL_LAT;
  localparam int S_OUT  = S_N + 1;

  typedef struct packed {
    qent_t e;
    word_t hx;
    word_t hy;
    word_t hz;
  } b1_t;

  typedef struct packed {
    word_t px;
    word_t py;
    word_t hx;
    word_t hy;
    word_t hz;
    word_t nxp;
    word_t nyp;
    word_t nzp;
    logic  vzneg;
    logic  hit;
  } b2_t;

  logic en;
  logic [S_OUT:0] bv;
  b1_t bc1 [S_Q+1];
  b2_t bc2 [S_Q+1:S_N];

  // Values that follow from the configuration alone.
  word_t kp1, c2, m_cc, m_ck2, m_cck, m_cckk;

  word_t r, den, t, m_tvx, m_tvy, m_tvz;
  word_t m_a, m_b, m_c, q1, q1b, qv;
  word_t m_hzc, m_hzck, zz, m_hxc, m_hyc;
  word_t rq, sg, coef, m_nx, m_ny, m_nz;

  assign en = !(bv[S_OUT] && out_stall);
  assign q_pop = q_valid && en;
  assign out_valid = bv[S_OUT];
  assign sg = bc2[S_RQ].vzneg ? -ONE : ONE;

  always_ff @(posedge clk) begin
    kp1 <= sat_add(conic, ONE);
    c2 <= sat_add(curv, curv);
  end

  cshr_mul u_cc   (.clk(clk), .en(1'b1), .a(curv), .b(curv), .p(m_cc));
  cshr_mul u_ck2  (.clk(clk), .en(1'b1), .a(c2), .b(conic), .p(m_ck2));
  cshr_mul u_cck  (.clk(clk), .en(1'b1), .a(m_cc), .b(kp1), .p(m_cck));
  cshr_mul u_cckk (.clk(clk), .en(1'b1), .a(m_cck), .b(conic), .p(m_cckk));

  cshr_sqrt u_sqrt_h (.clk(clk), .en(en), .v(bc1[0].e.h), .r(r));
  cshr_div  u_div_t  (.clk(clk), .en(en), .n(bc1[S_DEN].e.f), .d(den), .q(t));

  cshr_mul u_tvx (.clk(clk), .en(en), .a(t), .b(bc1[S_T].e.vx), .p(m_tvx));
  cshr_mul u_tvy (.clk(clk), .en(en), .a(t), .b(bc1[S_T].e.vy), .p(m_tvy));
  cshr_mul u_tvz (.clk(clk), .en(en), .a(t), .b(bc1[S_T].e.vz), .p(m_tvz));

  cshr_mul u_a    (.clk(clk), .en(en), .a(m_ck2), .b(m_tvz), .p(m_a));
  cshr_mul u_b    (.clk(clk), .en(en), .a(m_cckk), .b(m_tvz), .p(m_b));
  cshr_mul u_c    (.clk(clk), .en(en), .a(m_b), .b(bc1[S_A].hz), .p(m_c));
  cshr_mul u_hzc  (.clk(clk), .en(en), .a(m_tvz), .b(curv), .p(m_hzc));
  cshr_mul u_hzck (.clk(clk), .en(en), .a(m_hzc), .b(kp1), .p(m_hzck));
  cshr_mul u_hxc  (.clk(clk), .en(en), .a(bc1[S_Q1].hx), .b(curv), .p(m_hxc));
  cshr_mul u_hyc  (.clk(clk), .en(en), .a(bc1[S_Q1].hy), .b(curv), .p(m_hyc));

  cshr_sqrt u_sqrt_q (.clk(clk), .en(en), .v(qv), .r(rq));
  cshr_div  u_div_c  (.clk(clk), .en(en), .n(sg), .d(rq), .q(coef));

  cshr_mul u_nx (.clk(clk), .en(en), .a(bc2[S_COEF].nxp), .b(coef), .p(m_nx));
  cshr_mul u_ny (.clk(clk), .en(en), .a(bc2[S_COEF].nyp), .b(coef), .p(m_ny));
  cshr_mul u_nz (.clk(clk), .en(en), .a(bc2[S_COEF].nzp), .b(coef), .p(m_nz));

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
    end else if (en) begin
      bv[0] <= q_valid;
      for (int i = 1; i <= S_OUT; i++) bv[i] <= bv[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bc1[0].e <= q_head;
      bc1[0].hx <= '0;
      bc1[0].hy <= '0;
      bc1[0].hz <= '0;
      for (int i = 1; i < S_HX; i++) bc1[i] <= bc1[i-1];
      bc1[S_HX] <= '{e: bc1[S_HZ].e, hx: sat_add(bc1[S_HZ].e.px, m_tvx),
                     hy: sat_add(bc1[S_HZ].e.py, m_tvy), hz: m_tvz};
      for (int i = S_HX + 1; i <= S_Q; i++) bc1[i] <= bc1[i-1];

      // Sign of the root follows the sign of dir_z.
      den <= bc1[S_R].e.vz[W-1] ? sat_sub(bc1[S_R].e.g, r) : sat_add(bc1[S_R].e.g, r);
      q1 <= sat_sub(ONE, m_a);
      q1b <= q1;
      qv <= sat_add(q1b, m_c);
      zz <= sat_sub(m_hzck, ONE);

      bc2[S_Q+1].px <= bc1[S_Q].e.px;
      bc2[S_Q+1].py <= bc1[S_Q].e.py;
      bc2[S_Q+1].hx <= bc1[S_Q].hx;
      bc2[S_Q+1].hy <= bc1[S_Q].hy;
      bc2[S_Q+1].hz <= bc1[S_Q].hz;
      bc2[S_Q+1].nxp <= m_hxc;
      bc2[S_Q+1].nyp <= m_hyc;
      bc2[S_Q+1].nzp <= zz;
      bc2[S_Q+1].vzneg <= bc1[S_Q].e.vz[W-1];
      bc2[S_Q+1].hit <= bc1[S_Q].e.hit;
      for (int i = S_Q + 2; i <= S_N; i++) bc2[i] <= bc2[i-1];

      if (bc2[S_N].hit) begin
        hit_x <= bc2[S_N].hx;
        hit_y <= bc2[S_N].hy;
        hit_z <= bc2[S_N].hz;
        norm_x <= m_nx;
        norm_y <= m_ny;
        norm_z <= m_nz;
        status <= 1'b0;
      end else begin
        hit_x <= bc2[S_N].px;
        hit_y <= bc2[S_N].py;
        hit_z <= '0;
        norm_x <= '0;
        norm_y <= '0;
        norm_z <= '0;
        status <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/conic_surface_ray_hit_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// conic_surface_ray_hit_core: ray intersection with a conic optical surface
// Rays enter on the input channel (in_valid / in_stall) and each leaves as
// exactly one result on the output channel (out_valid / out_stall), in order.
// A ray is taken when in_valid is high and in_stall is low; a result is taken
// when out_valid is high and out_stall is low.
// Throughput is one ray per clock while neither pipeline stalls. Each ray
// passes through the front pipeline, the queue and the back pipeline,
// which holds two square roots and two divisions at one bit per stage.
// The front and back pipelines stall separately; a four-entry queue sits
// between them. When out_stall is high with out_valid high, the back
// pipeline holds its contents and the result stays on the output; the
// front keeps taking rays until the queue fills, then raises in_stall.
// Reset (rst, synchronous) empties both pipelines and the queue and clears
// curvature and conic_constant to zero. Users must write the registers via
// cfg_write / cfg_index / cfg_data while no ray is in flight (unchecked).
// ----------------------------------------------------------------------------
module conic_surface_ray_hit_core import cshr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_write,
  input  logic  cfg_index,
  input  word_t cfg_data,
  input  logic  in_valid,
  output logic  in_stall,
  input  word_t pos_x,
  input  word_t pos_y,
  input  word_t dir_x,
  input  word_t dir_y,
  input  word_t dir_z,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t hit_x,
  output word_t hit_y,
  output word_t hit_z,
  output word_t norm_x,
  output word_t norm_y,
  output word_t norm_z,
  output logic  status
);

  word_t curv, conic;
  logic push, q_pop, q_full, q_valid;
  qent_t entry;
  qent_t qmem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      curv <= '0;
      conic <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CURVATURE: curv <= cfg_data;
        REG_CONIC:     conic <= cfg_data;
        default:       curv <= curv;
      endcase
    end
  end

  cshr_front u_front (
    .clk(clk), .rst(rst), .curv(curv), .conic(conic),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_x(pos_x), .pos_y(pos_y), .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .q_full(q_full), .q_pop(q_pop), .push(push), .entry(entry)
  );

  assign q_full = (q_count == QCNT_W'(QDEPTH));
  assign q_valid = (q_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      q_count <= q_count + QCNT_W'(push) - QCNT_W'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) qmem[wr_ptr] <= entry;
  end

  cshr_back u_back (
    .clk(clk), .rst(rst), .curv(curv), .conic(conic),
    .q_valid(q_valid), .q_head(qmem[rd_ptr]), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z), .status(status)
  );

  // A full queue only takes a transaction in a cycle that also drains one.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && q_full) |-> q_pop)
    else $error("queue written while full");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_full)
    else $error("input stalled with room in the queue");

  a_no_hit_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (hit_z == '0 && norm_x == '0 && norm_y == '0
                               && norm_z == '0))
    else $error("miss result carries a hit point or normal");

endmodule
`default_nettype wire
